/* rtl/sbt_pkg.sv */
// types, codes and constants shared by the study/break timer controller
package sbt_pkg;

  // session modes, one-hot
  typedef enum logic [5:0] {
    M_SETTING    = 6'b000001,
    M_STUDYING   = 6'b000010,
    M_PAUSED     = 6'b000100,
    M_BREAK_DUE  = 6'b001000,
    M_ON_BREAK   = 6'b010000,
    M_BREAK_OVER = 6'b100000
  } mode_t;

  // mode codes as seen on the result beat
  localparam logic [2:0] CODE_SETTING    = 3'd0;
  localparam logic [2:0] CODE_STUDYING   = 3'd1;
  localparam logic [2:0] CODE_PAUSED     = 3'd2;
  localparam logic [2:0] CODE_BREAK_DUE  = 3'd3;
  localparam logic [2:0] CODE_ON_BREAK   = 3'd4;
  localparam logic [2:0] CODE_BREAK_OVER = 3'd5;

  // input beat kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_BREAK_SECONDS = 2'd0;
  localparam logic [1:0] REG_PRESS_POLLS   = 2'd1;
  localparam logic [1:0] REG_LOCKOUT_MS    = 2'd2;

  localparam logic [11:0] BREAK_SECONDS_RESET = 12'd900;
  localparam logic [7:0]  PRESS_POLLS_RESET   = 8'd4;
  localparam logic [15:0] LOCKOUT_MS_RESET    = 16'd200;

  // led bits {red, green, blue}
  localparam logic [2:0] LED_RED   = 3'b100;
  localparam logic [2:0] LED_GRN   = 3'b010;
  localparam logic [2:0] LED_BLUE  = 3'b001;
  localparam logic [2:0] LED_OFF   = 3'b000;

  localparam logic [7:0]  DIGIT_ZERO   = 8'h3F;
  localparam logic [7:0]  LOW_RUN_MAX  = 8'd255;
  localparam logic [12:0] SEC_ROUND_UP = 13'd59;
  // floor(x / 60) = (x * 4370) >> 18, exact for x below 4155
  localparam logic [25:0] MIN_RECIP    = 26'd4370;
  localparam int          MIN_SHIFT    = 18;

  typedef struct packed {
    logic        op;
    logic        level;
    logic [31:0] now_ms;
    logic [5:0]  minutes;
  } in_beat_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      M_SETTING:    c = CODE_SETTING;
      M_STUDYING:   c = CODE_STUDYING;
      M_PAUSED:     c = CODE_PAUSED;
      M_BREAK_DUE:  c = CODE_BREAK_DUE;
      M_ON_BREAK:   c = CODE_ON_BREAK;
      M_BREAK_OVER: c = CODE_BREAK_OVER;
      default:      c = CODE_SETTING;
    endcase
    return c;
  endfunction

endpackage

/* rtl/study_break_timer_controller.sv */
// Study/break session timer controller: one result beat for every input beat, a tick or a
// button poll. Beats enter an input register and are resolved, once the result register is
// free or being taken, into a result register, so one beat per clock is sustained while the
// output is not stalled. The result beat is held until it is taken. The single pass of mode,
// debounce, lockout and countdown logic lies between those two registers.
// Configuration writes are always ready and take effect on the next beat resolved.
module study_break_timer_controller (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [39:0]             in_tdata,   // button_level, now_ms[31:0], study_minutes[5:0]
  input  logic                    in_tuser,   // operation
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // mode[2:0], seconds_left[11:0], mins_ceil[6:0], red_on, green_on, blue_on, buzzer,
  // segment_write, segment_pattern[7:0], press_taken
  output logic [39:0]             out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);
  import sbt_pkg::*;

  // configuration
  logic [11:0] break_seconds_r;
  logic [7:0]  press_polls_r;
  logic [15:0] lockout_ms_r;

  // input register
  logic     in_full_r;
  in_beat_t in_beat_r;
  logic     adv;

  // session state
  mode_t       mode_r, mode_nxt;
  mode_t       resume_r, resume_nxt;
  logic [11:0] countdown_r, countdown_nxt;
  logic        blink_r, blink_nxt;
  logic [7:0]  low_run_r, low_run_nxt;
  logic        latched_r, latched_nxt;
  logic [31:0] last_press_r, last_press_nxt;
  logic [2:0]  led_r, led_nxt;
  logic        buzzer_r, buzzer_nxt;

  // result register
  logic        out_valid_r;
  logic [35:0] out_data_r, out_data_nxt;

  logic        seg_write;
  logic [7:0]  seg_pattern;
  logic        press;
  logic [7:0]  need;
  logic [31:0] elapsed;
  logic [12:0] round_sum;
  logic [25:0] min_prod;
  logic [6:0]  mins_ceil;

  assign cfg_ready  = 1'b1;
  assign adv        = in_full_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_full_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_seconds_r <= BREAK_SECONDS_RESET;
      press_polls_r   <= PRESS_POLLS_RESET;
      lockout_ms_r    <= LOCKOUT_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BREAK_SECONDS: break_seconds_r <= cfg_data[11:0];
        REG_PRESS_POLLS:   press_polls_r   <= cfg_data[7:0];
        REG_LOCKOUT_MS:    lockout_ms_r    <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_tready) begin
      in_full_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_beat_r.op      <= in_tuser;
      in_beat_r.level   <= in_tdata[0];
      in_beat_r.now_ms  <= in_tdata[32:1];
      in_beat_r.minutes <= in_tdata[38:33];
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    resume_nxt     = resume_r;
    countdown_nxt  = countdown_r;
    blink_nxt      = blink_r;
    low_run_nxt    = low_run_r;
    latched_nxt    = latched_r;
    last_press_nxt = last_press_r;
    led_nxt        = led_r;
    buzzer_nxt     = buzzer_r;
    seg_write      = 1'b0;
    seg_pattern    = 8'h00;
    press          = 1'b0;
    need           = (press_polls_r == 8'd0) ? 8'd1 : press_polls_r;
    elapsed        = in_beat_r.now_ms - last_press_r;

    if (in_beat_r.op == OP_TICK) begin
      blink_nxt = !blink_r;
      unique case (mode_r)
        M_STUDYING: begin
          led_nxt = LED_GRN;
          if (countdown_r != 12'd0) countdown_nxt = countdown_r - 12'd1;
          if (countdown_r <= 12'd1) mode_nxt = M_BREAK_DUE;
        end
        M_PAUSED: begin
          led_nxt = LED_RED | LED_GRN;
        end
        M_BREAK_DUE: begin
          led_nxt     = blink_nxt ? LED_RED : LED_OFF;
          seg_write   = 1'b1;
          seg_pattern = blink_nxt ? DIGIT_ZERO : 8'h00;
          buzzer_nxt  = blink_nxt;
        end
        M_ON_BREAK: begin
          led_nxt = blink_nxt ? LED_BLUE : LED_OFF;
          if (countdown_r != 12'd0) countdown_nxt = countdown_r - 12'd1;
          if (countdown_r <= 12'd1) mode_nxt = M_BREAK_OVER;
        end
        M_BREAK_OVER: begin
          led_nxt    = blink_nxt ? LED_BLUE : LED_OFF;
          buzzer_nxt = blink_nxt;
        end
        default: ;
      endcase
    end else begin
      if (!in_beat_r.level) begin
        if (low_run_r != LOW_RUN_MAX) low_run_nxt = low_run_r + 8'd1;
      end else begin
        low_run_nxt = 8'd0;
        latched_nxt = 1'b0;
      end
      // debounce, one press per hold, then lockout since the last press
      if (low_run_nxt >= need && !latched_nxt && elapsed >= {16'd0, lockout_ms_r}) begin
        press          = 1'b1;
        last_press_nxt = in_beat_r.now_ms;
        latched_nxt    = 1'b1;
        unique case (mode_r)
          M_SETTING: begin
            countdown_nxt = {in_beat_r.minutes, 6'd0} - {4'd0, in_beat_r.minutes, 2'd0};
            mode_nxt      = M_STUDYING;
            led_nxt       = LED_GRN;
          end
          M_STUDYING: begin
            resume_nxt = M_STUDYING;
            mode_nxt   = M_PAUSED;
            led_nxt    = LED_RED | LED_GRN;
          end
          M_PAUSED: begin
            mode_nxt = resume_r;
            led_nxt  = (resume_r == M_STUDYING) ? LED_GRN : LED_BLUE;
          end
          M_BREAK_DUE: begin
            buzzer_nxt    = 1'b0;
            countdown_nxt = break_seconds_r;
            mode_nxt      = M_ON_BREAK;
            led_nxt       = LED_BLUE;
          end
          M_ON_BREAK: begin
            resume_nxt = M_ON_BREAK;
            mode_nxt   = M_PAUSED;
            led_nxt    = LED_RED | LED_GRN;
          end
          M_BREAK_OVER: begin
            buzzer_nxt = 1'b0;
            mode_nxt   = M_SETTING;
            led_nxt    = LED_BLUE;
          end
          default: ;
        endcase
      end
    end

    // ceiling of seconds over 60 by reciprocal multiply, never below one
    round_sum = {1'b0, countdown_nxt} + SEC_ROUND_UP;
    min_prod  = 26'(round_sum) * MIN_RECIP;
    mins_ceil = min_prod[MIN_SHIFT +: 7];
    if (mins_ceil == 7'd0) mins_ceil = 7'd1;

    out_data_nxt = {press, seg_pattern, seg_write, buzzer_nxt, led_nxt[0], led_nxt[1],
                    led_nxt[2], mins_ceil, countdown_nxt, mode_code(mode_nxt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_SETTING;
      resume_r     <= M_SETTING;
      countdown_r  <= 12'd0;
      blink_r      <= 1'b0;
      low_run_r    <= 8'd0;
      latched_r    <= 1'b0;
      last_press_r <= 32'd0;
      led_r        <= LED_BLUE;
      buzzer_r     <= 1'b0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      resume_r     <= resume_nxt;
      countdown_r  <= countdown_nxt;
      blink_r      <= blink_nxt;
      low_run_r    <= low_run_nxt;
      latched_r    <= latched_nxt;
      last_press_r <= last_press_nxt;
      led_r        <= led_nxt;
      buzzer_r     <= buzzer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_data_nxt;
  end

  // a tick never reports a press
  a_tick_no_press: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_beat_r.op == OP_TICK) |=> !out_data_r[35])
    else $error("press reported on a tick beat");

  // segment output only on a tick in break due
  a_seg_only_break_due: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !(in_beat_r.op == OP_TICK && mode_r == M_BREAK_DUE)) |=> !out_data_r[26])
    else $error("segment write outside a break-due tick");

  // countdown only grows when a press loads it
  a_countdown_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !press) |=> countdown_r <= $past(countdown_r))
    else $error("countdown grew without a press");

  // a held-low run stays saturated
  a_low_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_beat_r.op == OP_POLL && !in_beat_r.level && low_run_r == LOW_RUN_MAX)
    |=> low_run_r == LOW_RUN_MAX)
    else $error("low run wrapped");

endmodule
